// ===== rtl/sha1_mdu_pkg.sv =====
package sha1_mdu_pkg;

	// a..e working variables of the compression
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] K_CH  = 32'h5a827999;
	localparam logic [31:0] K_PAR = 32'h6ed9eba1;
	localparam logic [31:0] K_MAJ = 32'h8f1bbcdc;
	localparam logic [31:0] K_PAR2 = 32'hca62c1d6;

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [2:0] LAST_WORD  = 3'd4;
	localparam logic [7:0] PAD_MARK   = 8'h80;

endpackage

// ===== rtl/sha1_mdu_round.sv =====
module sha1_mdu_round (
	input  sha1_mdu_pkg::work_t cur,
	input  logic [31:0]         w,
	input  logic [6:0]          rnd,
	output sha1_mdu_pkg::work_t nxt
);

	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] t;

	always_comb begin
		case (rnd) inside
			[7'd0:7'd19]: begin
				f = cur.d ^ (cur.b & (cur.c ^ cur.d));
				k = sha1_mdu_pkg::K_CH;
			end
			[7'd20:7'd39]: begin
				f = cur.b ^ cur.c ^ cur.d;
				k = sha1_mdu_pkg::K_PAR;
			end
			[7'd40:7'd59]: begin
				f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
				k = sha1_mdu_pkg::K_MAJ;
			end
			default: begin
				f = cur.b ^ cur.c ^ cur.d;
				k = sha1_mdu_pkg::K_PAR2;
			end
		endcase
		t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + w + k;
		nxt.a = t;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

// ===== rtl/sha1_message_digest_unit.sv =====
// SHA-1 digest engine. Message bytes enter one per input beat into a 512-bit block
// register; a beat with only byte_present low and last_item low is a no-op. When a
// data beat fills a block, the block runs 80 rounds through a single round adder,
// one round per cycle, followed by the chaining add, and the input stalls until the
// add is done. A beat with last_item set (byte or not; a lone last beat opening a
// message hashes the empty message) starts padding: the 0x80 mark, zeros and the
// 64-bit bit length are shifted in one byte per cycle, followed by one compression,
// or two when 56 or more bytes were pending. The five digest words then leave as
// five output beats, word 0 first, final_word set on word 4, and the engine is ready
// for the next message with the initial chaining values restored.
module sha1_message_digest_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_ADD   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t               state_q;
	logic [31:0]          chain_q [5];
	logic [31:0]          w_q [16];
	logic [31:0]          w_byte [16];
	logic [31:0]          w_sched [16];
	logic [31:0]          sched_mix;
	sha1_mdu_pkg::work_t  work_q;
	sha1_mdu_pkg::work_t  work_nxt;
	logic [6:0]           rnd_q;
	logic [5:0]           fill_q;
	logic [54:0]          blk_q;
	logic [63:0]          len_q;
	logic                 pad_q;
	logic                 sent80_q;
	logic                 fit_q;
	logic                 final_blk_q;
	logic [2:0]           out_idx_q;
	logic                 in_acc;
	logic                 out_free;
	logic [7:0]           shift_byte;
	logic [7:0]           pad_byte;
	logic                 fit_now;
	logic [60:0]          total_bytes;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid | ~out_stall;

	assign pad_byte = !sent80_q ? sha1_mdu_pkg::PAD_MARK :
		((fit_q && fill_q >= sha1_mdu_pkg::LEN_POS) ? len_q[63:56] : 8'h00);
	assign shift_byte  = (state_q == ST_PAD) ? pad_byte : data_byte;
	// does the length fit behind the mark in the block being padded
	assign fit_now     = sent80_q ? fit_q : (fill_q < sha1_mdu_pkg::LEN_POS);
	assign total_bytes = {blk_q, fill_q} + 61'(byte_present);

	sha1_mdu_round u_round (
		.cur (work_q),
		.w   (w_q[0]),
		.rnd (rnd_q),
		.nxt (work_nxt)
	);

	// byte shift (big-endian fill) and message schedule shift
	always_comb begin
		for (int j = 0; j < 15; j++) begin
			w_byte[j]  = {w_q[j][23:0], w_q[j+1][31:24]};
			w_sched[j] = w_q[j+1];
		end
		w_byte[15]  = {w_q[15][23:0], shift_byte};
		sched_mix   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_sched[15] = {sched_mix[30:0], sched_mix[31]};
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if ((in_acc && byte_present) || state_q == ST_PAD) begin
			w_q <= w_byte;
		end else if (state_q == ST_ROUND) begin
			w_q <= w_sched;
		end
		if (in_acc && last_item) begin
			len_q <= {total_bytes, 3'b000};
		end else if (state_q == ST_PAD && sent80_q && fit_q &&
			fill_q >= sha1_mdu_pkg::LEN_POS) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (state_q == ST_ROUND) begin
			work_q <= work_nxt;
		end else begin
			work_q <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
		end
		if (state_q == ST_OUT && out_free) begin
			digest_word <= chain_q[out_idx_q];
			word_number <= out_idx_q;
			final_word  <= (out_idx_q == sha1_mdu_pkg::LAST_WORD);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chain_q     <= sha1_mdu_pkg::H_INIT;
			rnd_q       <= '0;
			fill_q      <= '0;
			blk_q       <= '0;
			pad_q       <= 1'b0;
			sent80_q    <= 1'b0;
			fit_q       <= 1'b0;
			final_blk_q <= 1'b0;
			out_idx_q   <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (byte_present) begin
							fill_q <= fill_q + 6'd1;
						end
						if (last_item) begin
							pad_q    <= 1'b1;
							sent80_q <= 1'b0;
						end
						if (byte_present && fill_q == sha1_mdu_pkg::LAST_POS) begin
							blk_q       <= blk_q + 55'd1;
							rnd_q       <= '0;
							final_blk_q <= 1'b0;
							state_q     <= ST_ROUND;
						end else if (last_item) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (!sent80_q) begin
						sent80_q <= 1'b1;
					end
					if (fill_q == sha1_mdu_pkg::LAST_POS) begin
						final_blk_q <= fit_now;
						// at block end; for an overflow block the length goes into the next one
						fit_q       <= 1'b1;
						rnd_q       <= '0;
						state_q     <= ST_ROUND;
					end else if (!sent80_q) begin
						fit_q <= fit_now;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == sha1_mdu_pkg::LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					chain_q[0] <= chain_q[0] + work_q.a;
					chain_q[1] <= chain_q[1] + work_q.b;
					chain_q[2] <= chain_q[2] + work_q.c;
					chain_q[3] <= chain_q[3] + work_q.d;
					chain_q[4] <= chain_q[4] + work_q.e;
					if (final_blk_q) begin
						out_idx_q <= '0;
						state_q   <= ST_OUT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == sha1_mdu_pkg::LAST_WORD) begin
							chain_q     <= sha1_mdu_pkg::H_INIT;
							blk_q       <= '0;
							pad_q       <= 1'b0;
							final_blk_q <= 1'b0;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> rnd_q <= sha1_mdu_pkg::LAST_ROUND)
		else $error("round counter out of range");

	a_out_block_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> fill_q == 6'd0 && pad_q)
		else $error("digest output with partial block");

	a_final_has_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD && final_blk_q |-> pad_q && fit_q && sent80_q)
		else $error("final block without length");

	a_final_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_word |-> word_number == sha1_mdu_pkg::LAST_WORD)
		else $error("final flag on wrong digest word");
`endif

endmodule

// ===== verif/tb_sha1_message_digest_unit.sv =====
module tb_sha1_message_digest_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	localparam logic [31:0] IV_WORD [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	typedef struct {
		logic [31:0] word;
		logic [2:0]  number;
		logic        fin;
	} digest_beat_t;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_present = 1'b0;
	logic        last_item = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        final_word;

	// predictor state
	logic [31:0] hash_state [5];
	logic [7:0]  block_bytes [64];
	int          block_fill;
	logic [60:0] done_bytes;

	digest_beat_t digest_words_due [$];
	logic [7:0]   msg_buf [$];

	int cycle_count = 0;
	int mismatch_count = 0;
	int burst_left = 0;
	int payload_beats = 0;
	int idle_beats = 0;
	int bytes_sent = 0;
	int messages_sent = 0;
	int words_checked = 0;
	int stall_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	sha1_message_digest_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.byte_present(byte_present),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digest_word(digest_word),
		.word_number(word_number),
		.final_word(final_word)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void compress_block();
		logic [31:0] sched [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		int i;
		for (i = 0; i < 16; i++)
			sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
				block_bytes[4*i+3]};
		for (i = 16; i < 80; i++)
			sched[i] = rotl(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = d ^ (b & (c ^ d));
				k = 32'h5a827999;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ed9eba1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8f1bbcdc;
			end else begin
				f = b ^ c ^ d;
				k = 32'hca62c1d6;
			end
			t = rotl(a, 5) + f + e + sched[i] + k;
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	function automatic void clear_hash();
		int i;
		for (i = 0; i < 5; i++)
			hash_state[i] = IV_WORD[i];
		block_fill = 0;
		done_bytes = '0;
	endfunction

	// one accepted beat; a last beat queues the five digest words
	function automatic void predict_beat(input logic [7:0] b, input logic bp, input logic last);
		logic [63:0] bit_len;
		digest_beat_t dw;
		int i;
		if (bp) begin
			block_bytes[block_fill] = b;
			block_fill++;
			if (block_fill == 64) begin
				compress_block();
				done_bytes += 61'd64;
				block_fill = 0;
			end
		end
		if (!last)
			return;
		// 61-bit byte count wraps, so the bit length wraps at 2^64
		bit_len = {done_bytes + 61'(block_fill), 3'b000};
		block_bytes[block_fill] = 8'h80;
		for (i = block_fill + 1; i < 64; i++)
			block_bytes[i] = 8'h00;
		if (block_fill >= 56) begin
			compress_block();
			for (i = 0; i < 64; i++)
				block_bytes[i] = 8'h00;
		end
		for (i = 0; i < 8; i++)
			block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
		compress_block();
		for (i = 0; i < 5; i++) begin
			dw.word = hash_state[i];
			dw.number = 3'(i);
			dw.fin = (i == 4);
			digest_words_due.push_back(dw);
		end
		clear_hash();
	endfunction

	function automatic void flag_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("[%0t] MISMATCH %s", $realtime, msg);
		mismatch_count++;
	endfunction

	always @(posedge clk) begin : check_digest
		digest_beat_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (digest_words_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected digest beat: word %h number %0d final %b",
					digest_word, word_number, final_word));
			end else begin
				due = digest_words_due.pop_front();
				words_checked++;
				if (digest_word !== due.word)
					flag_mismatch($sformatf("digest_word exp %h got %h (word %0d)",
						due.word, digest_word, due.number));
				if (word_number !== due.number)
					flag_mismatch($sformatf("word_number exp %0d got %0d",
						due.number, word_number));
				if (final_word !== due.fin)
					flag_mismatch($sformatf("final_word exp %b got %b (word %0d)",
						due.fin, final_word, due.number));
			end
		end
	end

	// receiver back-pressure, switching between patterns
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 300);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
			STALL_PERIODIC: out_stall <= (cycle_count % 3 == 0);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 8);
			default:        out_stall <= 1'b0;
		endcase
	end

	task automatic send_beat(input logic [7:0] b, input logic bp, input logic last);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		byte_present <= bp;
		last_item <= last;
		do @(posedge clk); while (in_stall);
		predict_beat(b, bp, last);
		if (bp || last)
			payload_beats++;
		else
			idle_beats++;
		if (bp)
			bytes_sent++;
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		release_input();
		while (digest_words_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic fill_random(input int len);
		int i;
		msg_buf.delete();
		for (i = 0; i < len; i++)
			msg_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	// sends msg_buf; the end marker rides on the last byte or on a lone beat
	task automatic send_message(input bit last_on_byte, input int idle_pct);
		int i;
		int n;
		n = msg_buf.size();
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < idle_pct)
				send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_beat(msg_buf[i], 1'b1, last_on_byte && (i == n - 1));
		end
		if (!(last_on_byte && n > 0))
			send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		messages_sent++;
	endtask

	task automatic test_empty_message();
		send_beat(8'hff, 1'b0, 1'b1);
		messages_sent++;
		wait_drained();
		send_beat(8'h00, 1'b0, 1'b1);
		messages_sent++;
	endtask

	task automatic test_short_messages();
		msg_buf = '{8'h61, 8'h62, 8'h63};
		send_message(1'b1, 0);
		msg_buf = '{8'h00};
		send_message(1'b0, 0);
		msg_buf = '{8'hff};
		send_message(1'b1, 0);
	endtask

	task automatic test_idle_beats();
		send_beat(8'hff, 1'b0, 1'b0);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'h5a, 1'b0, 1'b0);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'ha5, 1'b0, 1'b0);
		send_beat(8'hff, 1'b0, 1'b1);
		messages_sent++;
		wait_drained();
	endtask

	// one full block, then an end at byte 56 where the length no longer fits
	task automatic test_padding_edges();
		fill_random(120);
		send_message(1'b0, 0);
		wait_drained();
	endtask

	task automatic test_random_messages();
		int first_beat;
		int first_msg;
		int len;
		int idle_pct;
		int i;
		first_beat = payload_beats;
		first_msg = messages_sent;
		while (payload_beats - first_beat < 10 || messages_sent - first_msg < 3) begin
			len = $urandom_range(0, 6);
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 5;
				default: idle_pct = 20;
			endcase
			// noise between messages
			if ($urandom_range(0, 5) == 0)
				for (i = $urandom_range(1, 4); i > 0; i--)
					send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			fill_random(len);
			send_message(1'($urandom_range(0, 1)), idle_pct);
			if ($urandom_range(0, 3) == 0)
				wait_drained();
		end
	endtask

	initial begin
		clear_hash();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_message();
		test_short_messages();
		test_idle_beats();
		test_padding_edges();
		test_random_messages();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Hashed %0d messages: %0d bytes, %0d idle beats, message beats %0d",
			messages_sent, bytes_sent, idle_beats, payload_beats);
		$display("Checked %0d digest words under varied input gaps and output stalls",
			words_checked);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sha1_mdu_pkg.sv
rtl/sha1_mdu_round.sv
rtl/sha1_message_digest_unit.sv
verif/tb_sha1_message_digest_unit.sv
